/* hdl/fswt_pkg.sv */
// fswt_pkg: shared types, codes and helpers for the four-symbol wavelet tree
// depends on: nothing

package fswt_pkg;

   // bits per stored word and offset width inside a word
   localparam int WORD_BITS = 16;
   localparam int OFFS_BITS = 4;

   // request kinds
   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_ACCESS = 2'd1,
      KIND_RANK   = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT_READ,
      ST_ROOT_RANK,
      ST_LEAF_READ,
      ST_LEAF_RANK
   } state_type;

   // popcount of one word as four nibble sums
   function automatic logic [4:0] popcount16(input logic [WORD_BITS-1:0] w);
      logic [4:0] acc;
      acc = 5'd0;
      for (int i = 0; i < WORD_BITS / 4; i++) begin
         acc = acc + 5'(w[4*i]) + 5'(w[4*i+1]) + 5'(w[4*i+2]) + 5'(w[4*i+3]);
      end
      return acc;
   endfunction

endpackage

/* hdl/four_symbol_wavelet_tree_unit.sv */
// four_symbol_wavelet_tree_unit: top level, sequencer around one root and two
// leaf bit stores sharing one rank unit; depends on fswt_pkg, fswt_bit_store,
// fswt_rank_unit
//
// channel   ports                                             transfer
// request   start, busy, req_kind, req_symbol, req_position  start && !busy
// response  rsp_strobe, rsp_status, rsp_found_symbol,        rsp_strobe
//           rsp_occurrences
//
// append, error and unused requests: response in the cycle after the transfer,
// busy stays low, so a request may follow every cycle.
// access and rank: busy in root read, root rank, leaf read, leaf rank; two word
// reads (root store, then leaf store), each a registered ram read plus a rank step.
// reset clears the counts and the sequencer; no clearing pass over the rams.
// the receiver takes every response; nothing stalls the output.

module four_symbol_wavelet_tree_unit #(
   parameter int MAX_SYMBOLS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_symbol,
   input  logic [11:0] req_position,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_found_symbol,
   output logic [11:0] rsp_occurrences
);

   localparam int LW    = $clog2(MAX_SYMBOLS + 1);
   localparam int DEPTH = (MAX_SYMBOLS + fswt_pkg::WORD_BITS - 1) / fswt_pkg::WORD_BITS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WB    = fswt_pkg::WORD_BITS;
   localparam int OB    = fswt_pkg::OFFS_BITS;
   localparam int CMPW  = (LW > 12) ? LW : 12;

   fswt_pkg::state_type state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [1:0]    sym_ff, sym_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic          hi_ff, hi_in;
   logic [LW-1:0] r_ff, r_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [1:0]    rsp_found_ff, rsp_found_in;
   logic [11:0]   rsp_occ_ff, rsp_occ_in;

   logic          append_en;
   logic          is_access;
   logic [CMPW-1:0] pos_ext, len_ext;

   // store views
   logic [LW-1:0] root_len, root_ones, root_dir;
   logic [WB-1:0] root_word;
   logic [LW-1:0] zero_len, zero_ones, zero_dir;
   logic [WB-1:0] zero_word;
   logic [LW-1:0] one_len, one_ones, one_dir;
   logic [WB-1:0] one_word;

   // rank unit operands
   logic [LW-1:0] ru_index, ru_len, ru_total, ru_dir, ru_count;
   logic [WB-1:0] ru_word;
   logic          ru_bit, ru_sel;

   // root and leaf stores
   fswt_bit_store #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_root (
      .clock     (clock),
      .reset     (reset),
      .append_en (append_en),
      .append_bit(req_symbol[1]),
      .rd_addr   (pos_ff[AW+OB-1:OB]),
      .length    (root_len),
      .ones      (root_ones),
      .rd_dir    (root_dir),
      .rd_word   (root_word)
   );

   fswt_bit_store #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_leaf_zero (
      .clock     (clock),
      .reset     (reset),
      .append_en (append_en && !req_symbol[1]),
      .append_bit(req_symbol[0]),
      .rd_addr   (r_ff[AW+OB-1:OB]),
      .length    (zero_len),
      .ones      (zero_ones),
      .rd_dir    (zero_dir),
      .rd_word   (zero_word)
   );

   fswt_bit_store #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_leaf_one (
      .clock     (clock),
      .reset     (reset),
      .append_en (append_en && req_symbol[1]),
      .append_bit(req_symbol[0]),
      .rd_addr   (r_ff[AW+OB-1:OB]),
      .length    (one_len),
      .ones      (one_ones),
      .rd_dir    (one_dir),
      .rd_word   (one_word)
   );

   // rank unit operand select: root step, then the leaf chosen by the high bit
   assign is_access = (kind_ff == fswt_pkg::KIND_ACCESS);

   always_comb begin
      if (state_ff == fswt_pkg::ST_ROOT_RANK) begin
         ru_index = pos_ff;
         ru_len   = root_len;
         ru_total = root_ones;
         ru_dir   = root_dir;
         ru_word  = root_word;
         ru_bit   = is_access ? ru_sel : sym_ff[1];
      end else if (hi_ff) begin
         ru_index = r_ff;
         ru_len   = one_len;
         ru_total = one_ones;
         ru_dir   = one_dir;
         ru_word  = one_word;
         ru_bit   = is_access ? ru_sel : sym_ff[0];
      end else begin
         ru_index = r_ff;
         ru_len   = zero_len;
         ru_total = zero_ones;
         ru_dir   = zero_dir;
         ru_word  = zero_word;
         ru_bit   = is_access ? ru_sel : sym_ff[0];
      end
   end

   fswt_rank_unit #(.LW(LW)) u_rank (
      .index     (ru_index),
      .length    (ru_len),
      .total_ones(ru_total),
      .dir       (ru_dir),
      .word      (ru_word),
      .count_bit (ru_bit),
      .sel_bit   (ru_sel),
      .count     (ru_count)
   );

   assign pos_ext = CMPW'(req_position);
   assign len_ext = CMPW'(root_len);

   // sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      sym_in        = sym_ff;
      pos_in        = pos_ff;
      hi_in         = hi_ff;
      r_in          = r_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      append_en     = 1'b0;
      case (state_ff)
         fswt_pkg::ST_IDLE: begin
            if (start) begin
               kind_in      = req_kind;
               sym_in       = req_symbol;
               pos_in       = LW'(req_position);
               rsp_status_in = fswt_pkg::STATUS_OK;
               rsp_found_in = 2'd0;
               rsp_occ_in   = 12'd0;
               case (req_kind)
                  fswt_pkg::KIND_APPEND: begin
                     rsp_strobe_in = 1'b1;
                     if (root_len == LW'(MAX_SYMBOLS)) begin
                        rsp_status_in = fswt_pkg::STATUS_FULL;
                     end else begin
                        append_en = 1'b1;
                     end
                  end
                  fswt_pkg::KIND_ACCESS: begin
                     if (pos_ext >= len_ext) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = fswt_pkg::STATUS_RANGE;
                     end else begin
                        state_in = fswt_pkg::ST_ROOT_READ;
                     end
                  end
                  fswt_pkg::KIND_RANK: begin
                     if (pos_ext > len_ext) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = fswt_pkg::STATUS_RANGE;
                     end else begin
                        state_in = fswt_pkg::ST_ROOT_READ;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         fswt_pkg::ST_ROOT_READ: begin
            state_in = fswt_pkg::ST_ROOT_RANK;
         end
         fswt_pkg::ST_ROOT_RANK: begin
            hi_in    = ru_bit;
            r_in     = ru_count;
            state_in = fswt_pkg::ST_LEAF_READ;
         end
         fswt_pkg::ST_LEAF_READ: begin
            state_in = fswt_pkg::ST_LEAF_RANK;
         end
         fswt_pkg::ST_LEAF_RANK: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = fswt_pkg::STATUS_OK;
            rsp_found_in  = is_access ? {hi_ff, ru_bit} : 2'd0;
            rsp_occ_in    = 12'(ru_count);
            state_in      = fswt_pkg::ST_IDLE;
         end
         default: begin
            state_in = fswt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fswt_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      sym_ff        <= sym_in;
      pos_ff        <= pos_in;
      hi_ff         <= hi_in;
      r_ff          <= r_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign busy             = (state_ff != fswt_pkg::ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_symbol = rsp_found_ff;
   assign rsp_occurrences  = rsp_occ_ff;

endmodule

/* hdl/fswt_ram.sv */
// fswt_ram: generic simple dual port ram with registered read
// depends on: nothing

module fswt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fswt_bit_store.sv */
// fswt_bit_store: append-only bit sequence kept as words, each with a count
// of ones before it; depends on fswt_pkg and fswt_ram

module fswt_bit_store #(
   parameter int MAX_SYMBOLS = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic append_en,
   input  logic append_bit,
   input  logic [((MAX_SYMBOLS + fswt_pkg::WORD_BITS - 1) / fswt_pkg::WORD_BITS > 1 ?
                  $clog2((MAX_SYMBOLS + fswt_pkg::WORD_BITS - 1) / fswt_pkg::WORD_BITS) :
                  1)-1:0] rd_addr,
   output logic [$clog2(MAX_SYMBOLS + 1)-1:0] length,
   output logic [$clog2(MAX_SYMBOLS + 1)-1:0] ones,
   output logic [$clog2(MAX_SYMBOLS + 1)-1:0] rd_dir,
   output logic [fswt_pkg::WORD_BITS-1:0]     rd_word
);

   localparam int LW    = $clog2(MAX_SYMBOLS + 1);
   localparam int DEPTH = (MAX_SYMBOLS + fswt_pkg::WORD_BITS - 1) / fswt_pkg::WORD_BITS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WB    = fswt_pkg::WORD_BITS;
   localparam int OB    = fswt_pkg::OFFS_BITS;

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] ones_ff, ones_in;
   logic [WB-1:0] tail_word_ff, tail_word_in;
   logic [LW-1:0] tail_dir_ff, tail_dir_in;
   logic [OB-1:0] offset;
   logic [LW+WB-1:0] rd_data;

   assign offset = len_ff[OB-1:0];

   // merge the new bit into the tail word; a fresh word takes the running count
   always_comb begin
      len_in       = len_ff;
      ones_in      = ones_ff;
      tail_word_in = tail_word_ff;
      tail_dir_in  = tail_dir_ff;
      if (append_en) begin
         len_in  = len_ff + LW'(1);
         ones_in = ones_ff + LW'(append_bit);
         if (offset == '0) begin
            tail_word_in = WB'(append_bit);
            tail_dir_in  = ones_ff;
         end else begin
            tail_word_in = tail_word_ff | (WB'(append_bit) << offset);
         end
      end
   end

   // counts
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         ones_ff <= '0;
      end else begin
         len_ff  <= len_in;
         ones_ff <= ones_in;
      end
   end

   // tail word payload
   always_ff @(posedge clock) begin
      tail_word_ff <= tail_word_in;
      tail_dir_ff  <= tail_dir_in;
   end

   fswt_ram #(
      .WIDTH(LW + WB),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (append_en),
      .wr_addr(len_ff[AW+OB-1:OB]),
      .wr_data({tail_dir_in, tail_word_in}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign length  = len_ff;
   assign ones    = ones_ff;
   assign rd_dir  = rd_data[LW+WB-1:WB];
   assign rd_word = rd_data[WB-1:0];

endmodule

/* hdl/fswt_rank_unit.sv */
// fswt_rank_unit: shared rank step, counts a bit value below an index
// from a word, its directory count and the store totals; depends on fswt_pkg

module fswt_rank_unit #(
   parameter int LW = 13
) (
   input  logic [LW-1:0]                  index,
   input  logic [LW-1:0]                  length,
   input  logic [LW-1:0]                  total_ones,
   input  logic [LW-1:0]                  dir,
   input  logic [fswt_pkg::WORD_BITS-1:0] word,
   input  logic                           count_bit,
   output logic                           sel_bit,
   output logic [LW-1:0]                  count
);

   localparam int WB = fswt_pkg::WORD_BITS;
   localparam int OB = fswt_pkg::OFFS_BITS;

   logic [OB-1:0] offset;
   logic [WB-1:0] below_mask;
   logic [LW-1:0] ones_word;
   logic [LW-1:0] ones;

   assign offset     = index[OB-1:0];
   assign below_mask = (WB'(1) << offset) - WB'(1);
   assign sel_bit    = word[offset];

   // ones before index; at the end of the store the running total stands in
   assign ones_word = dir + LW'(fswt_pkg::popcount16(word & below_mask));
   assign ones      = (index == length) ? total_ones : ones_word;

   // zeros are the rest
   assign count = count_bit ? ones : (index - ones);

endmodule

/* hdl/fswt_checker.sv */
// fswt_checker: port-level checks on the wavelet tree unit, bound to the top
// depends on: fswt_pkg, four_symbol_wavelet_tree_unit

module fswt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_kind,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [1:0]  rsp_found_symbol,
   input logic [11:0] rsp_occurrences
);

   // every transfer is answered at once or makes the unit busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("transfer neither answered nor started");

   // unused kind answers ok with empty fields in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == fswt_pkg::KIND_UNUSED) |=>
      (rsp_strobe && rsp_status == fswt_pkg::STATUS_OK &&
       rsp_found_symbol == 2'd0 && rsp_occurrences == 12'd0))
      else $error("unused kind response wrong");

   // an error response carries no symbol and no count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != fswt_pkg::STATUS_OK) |->
      (rsp_found_symbol == 2'd0 && rsp_occurrences == 12'd0))
      else $error("error response with data");

   // responses come only once the sequencer is back to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   // a query that makes the unit busy answers as busy falls
   assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy) && !$past(reset)) |=> ##2 (busy ##1 (!busy && rsp_strobe)))
      else $error("query latency wrong");

endmodule

bind four_symbol_wavelet_tree_unit fswt_checker u_fswt_checker (.*);

/* tb/four_symbol_wavelet_tree_unit_tb.sv */
// four_symbol_wavelet_tree_unit_tb: self-checking bench for the wavelet tree unit,
// with appends, access and rank queries, a tree predictor and a response checker
// depends on: fswt_pkg, four_symbol_wavelet_tree_unit

module four_symbol_wavelet_tree_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_SYMBOLS = 4096;
   localparam int unsigned RANDOM_REQUESTS = 1750;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PRINT_LIMIT = 40;

   // one request as queued for the driver
   typedef struct {
      fswt_pkg::kind_type kind;
      logic [1:0]  symbol;
      logic [11:0] position;
      int unsigned gap;
      bit          drain;
   } tree_request_type;

   // one predicted response
   typedef struct {
      fswt_pkg::status_type status;
      logic [1:0]  symbol;
      logic [11:0] occurrences;
   } tree_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = 2'd0;
   logic [1:0]  req_symbol = 2'd0;
   logic [11:0] req_position = 12'd0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_found_symbol;
   logic [11:0] rsp_occurrences;

   tree_request_type requests_pending[$];
   tree_answer_type  answers_due[$];
   tree_request_type held_request;

   // predictor state: level 0 is the root, 1 the zero-side leaf, 2 the one-side leaf
   bit          tree_bits[3][MAX_SYMBOLS];
   int unsigned sequence_length = 0;
   int unsigned leaf_length[2] = '{0, 0};

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned idle_count = 0;
   int unsigned kinds_sent[4] = '{0, 0, 0, 0};
   int unsigned answers_checked = 0;
   int unsigned full_answers = 0;
   int unsigned range_answers = 0;
   bit          no_idle_stretch = 1'b0;

   four_symbol_wavelet_tree_unit #(
      .MAX_SYMBOLS(MAX_SYMBOLS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_found_symbol(rsp_found_symbol),
      .rsp_occurrences (rsp_occurrences)
   );

   always #5 clock = ~clock;

   // entries equal to value among the first count of one level
   function automatic int unsigned count_bit(input int level, input int unsigned count,
                                             input bit value);
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < count && i < MAX_SYMBOLS; i++) begin
         if (tree_bits[level][i] == value) n++;
      end
      return n;
   endfunction

   // apply one request to the tree copy and work out its response
   function automatic tree_answer_type tree_step(input tree_request_type rq);
      tree_answer_type answer;
      bit           hi;
      bit           lo;
      int unsigned  root_rank;
      answer = '{status: fswt_pkg::STATUS_OK, symbol: 2'd0, occurrences: 12'd0};
      case (rq.kind)
         fswt_pkg::KIND_APPEND: begin
            if (sequence_length >= MAX_SYMBOLS) begin
               answer.status = fswt_pkg::STATUS_FULL;
            end else begin
               hi = rq.symbol[1];
               lo = rq.symbol[0];
               tree_bits[0][sequence_length] = hi;
               sequence_length++;
               tree_bits[1 + hi][leaf_length[hi]] = lo;
               leaf_length[hi]++;
            end
         end
         fswt_pkg::KIND_ACCESS: begin
            if (rq.position >= sequence_length) begin
               answer.status = fswt_pkg::STATUS_RANGE;
            end else begin
               hi = tree_bits[0][rq.position];
               root_rank = count_bit(0, rq.position, hi);
               lo = (root_rank < leaf_length[hi]) ? tree_bits[1 + hi][root_rank] : 1'b0;
               answer.symbol = {hi, lo};
               answer.occurrences = 12'(count_bit(1 + hi, root_rank, lo));
            end
         end
         fswt_pkg::KIND_RANK: begin
            if (rq.position > sequence_length) begin
               answer.status = fswt_pkg::STATUS_RANGE;
            end else begin
               hi = rq.symbol[1];
               lo = rq.symbol[0];
               root_rank = count_bit(0, rq.position, hi);
               answer.occurrences = 12'(count_bit(1 + hi, root_rank, lo));
            end
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0d] mismatch: %s", cycle_count, msg);
   endtask

   // add one request with its idle gap
   task automatic queue_request(input fswt_pkg::kind_type kind, input logic [1:0] symbol,
                                input logic [11:0] position, input bit drain);
      tree_request_type rq;
      rq.kind = kind;
      rq.symbol = symbol;
      rq.position = position;
      rq.gap = no_idle_stretch ? 0 : $urandom_range(0, 19);
      rq.drain = drain;
      requests_pending.insert(requests_pending.size(), rq);
   endtask

   // query position: mostly inside the sequence, sometimes on or past its end
   function automatic logic [11:0] pick_position(input int unsigned length);
      int unsigned choice;
      choice = $urandom_range(0, 9);
      if (choice == 0) return 12'($urandom_range(0, 4095));
      if (choice == 1) return 12'((length > 4095) ? 4095 : length);
      if (choice == 2) return 12'((length + 1 > 4095) ? 4095 : length + 1);
      return 12'($urandom_range(0, (length > 0) ? length - 1 : 0));
   endfunction

   // driver: one request at a time, held until the block takes it
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_count <= 0;
      end else begin
         if (start && !busy) begin
            answers_due.insert(answers_due.size(), tree_step(held_request));
            kinds_sent[held_request.kind]++;
         end
         if (start && busy) begin
            // waiting for the transfer
         end else if (requests_pending.size() == 0) begin
            start <= 1'b0;
         end else if (idle_count < requests_pending[0].gap) begin
            idle_count <= idle_count + 1;
            start <= 1'b0;
         end else if (requests_pending[0].drain && answers_due.size() != 0) begin
            start <= 1'b0;
         end else begin
            held_request = requests_pending.pop_front();
            start <= 1'b1;
            req_kind <= held_request.kind;
            req_symbol <= held_request.symbol;
            req_position <= held_request.position;
            idle_count <= 0;
         end
      end
   end

   // monitor: a strobe is stable over its cycle, so sample it mid-cycle
   always @(negedge clock) begin
      tree_answer_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (answers_due.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            want = answers_due.pop_front();
            answers_checked++;
            if (want.status == fswt_pkg::STATUS_FULL) full_answers++;
            if (want.status == fswt_pkg::STATUS_RANGE) range_answers++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_status, want.status));
            if (rsp_found_symbol !== want.symbol)
               report_mismatch($sformatf("found_symbol got %0d expected %0d",
                                         rsp_found_symbol, want.symbol));
            if (rsp_occurrences !== want.occurrences)
               report_mismatch($sformatf("occurrences got %0d expected %0d",
                                         rsp_occurrences, want.occurrences));
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, answers_due.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned planned_length;
      int unsigned pick;
      logic [1:0]  sym;

      planned_length = 0;

      // empty store: range errors, rank over nothing, unused kind
      queue_request(fswt_pkg::KIND_ACCESS, 2'd0, 12'd0, 1'b0);
      queue_request(fswt_pkg::KIND_RANK, 2'd0, 12'd0, 1'b0);
      queue_request(fswt_pkg::KIND_RANK, 2'd3, 12'd1, 1'b0);
      queue_request(fswt_pkg::KIND_ACCESS, 2'd3, 12'd4095, 1'b0);
      queue_request(fswt_pkg::KIND_RANK, 2'd1, 12'd4095, 1'b0);
      queue_request(fswt_pkg::KIND_UNUSED, 2'd3, 12'd4095, 1'b0);
      // one of each symbol, then read them back
      for (int s = 0; s < 4; s++)
         queue_request(fswt_pkg::KIND_APPEND, 2'(s), 12'(4095 - s), 1'b0);
      planned_length = 4;
      for (int p = 0; p < 4; p++) queue_request(fswt_pkg::KIND_ACCESS, 2'(p), 12'(p), 1'b0);
      // rank over the whole sequence, one past its end and access at its end
      for (int s = 0; s < 4; s++) queue_request(fswt_pkg::KIND_RANK, 2'(s), 12'd4, 1'b0);
      queue_request(fswt_pkg::KIND_RANK, 2'd2, 12'd5, 1'b0);
      queue_request(fswt_pkg::KIND_ACCESS, 2'd1, 12'd4, 1'b0);
      queue_request(fswt_pkg::KIND_RANK, 2'd3, 12'd0, 1'b0);

      // random mix; the sequence grows while it is queried
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 0) no_idle_stretch = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         sym = 2'($urandom_range(0, 3));
         if (pick < 40) begin
            queue_request(fswt_pkg::KIND_APPEND, sym, 12'($urandom_range(0, 4095)),
                          n == 0 || $urandom_range(0, 99) == 0);
            planned_length++;
         end else if (pick < 65) begin
            queue_request(fswt_pkg::KIND_ACCESS, sym, pick_position(planned_length),
                          $urandom_range(0, 99) == 0);
         end else if (pick < 90) begin
            queue_request(fswt_pkg::KIND_RANK, sym, pick_position(planned_length), 1'b0);
         end else if (pick < 95) begin
            queue_request(fswt_pkg::KIND_UNUSED, sym, 12'($urandom_range(0, 4095)), 1'b0);
         end else begin
            queue_request(fswt_pkg::kind_type'($urandom_range(0, 3)), sym,
                          12'($urandom_range(0, 4095)), 1'b0);
            if (requests_pending[$].kind == fswt_pkg::KIND_APPEND) planned_length++;
         end
      end

      // drain, then a rank over the grown sequence
      no_idle_stretch = 1'b0;
      queue_request(fswt_pkg::KIND_RANK, 2'd2, pick_position(planned_length), 1'b1);

      // late requests: append after a drain, queries at the far end and at the start
      queue_request(fswt_pkg::KIND_APPEND, 2'd3, 12'd0, 1'b1);
      queue_request(fswt_pkg::KIND_APPEND, 2'd0, 12'd4095, 1'b0);
      queue_request(fswt_pkg::KIND_ACCESS, 2'd0, 12'd4095, 1'b0);
      queue_request(fswt_pkg::KIND_ACCESS, 2'd3, 12'd0, 1'b0);
      for (int s = 0; s < 4; s++) queue_request(fswt_pkg::KIND_RANK, 2'(s), 12'd4095, 1'b0);
      queue_request(fswt_pkg::KIND_UNUSED, 2'd0, 12'd0, 1'b0);

      // hold reset, then release it
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait for every transfer and every response
      while (requests_pending.size() != 0 || start || answers_due.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d appends, %0d access, %0d rank and %0d unused-kind requests",
               kinds_sent[fswt_pkg::KIND_APPEND], kinds_sent[fswt_pkg::KIND_ACCESS],
               kinds_sent[fswt_pkg::KIND_RANK], kinds_sent[fswt_pkg::KIND_UNUSED]);
      $display("%0d responses checked, %0d store full, %0d out of range, final length %0d",
               answers_checked, full_answers, range_answers, sequence_length);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/fswt_pkg.sv
hdl/fswt_ram.sv
hdl/fswt_bit_store.sv
hdl/fswt_rank_unit.sv
hdl/four_symbol_wavelet_tree_unit.sv
hdl/fswt_checker.sv
tb/four_symbol_wavelet_tree_unit_tb.sv
